[rtl/core/pimrs_pkg.sv]
package pimrs_pkg;

   // queue and channel geometry
   localparam int NUM_CHANNELS = 16;
   localparam int CHAN_W       = 4;
   localparam int QUEUE_DEPTH  = 256;
   localparam int QADDR_W      = 8;
   localparam int QCNT_W       = 9;
   localparam int ROW_W        = 14;
   localparam int TAG_W        = 8;
   localparam int KIND_W       = 2;

   // time widths: clock counts and picosecond stamps
   localparam int TIME_W       = 48;
   localparam int HALF_W       = TIME_W / 2;
   localparam int PS_W         = 61;
   localparam int IVAL_W       = 20;
   localparam int PER_W        = 12;
   localparam int DLY_W        = 8;
   localparam int DIV_CNT_W    = 6;

   // control register port
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_MAC_INTERVAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IO_INTERVAL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_PERIOD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUAL_ROW     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACT_DELAY    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_DELAY    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_LAT     = 3'd6;

   localparam logic [IVAL_W-1:0] MAC_INTERVAL_RST = 20'd24576;
   localparam logic [IVAL_W-1:0] IO_INTERVAL_RST  = 20'd1024;
   localparam logic [PER_W-1:0]  CLOCK_PERIOD_RST = 12'd1000;
   localparam logic [DLY_W-1:0]  ACT_DELAY_RST    = 8'd14;
   localparam logic [DLY_W-1:0]  PRE_DELAY_RST    = 8'd14;
   localparam logic [DLY_W-1:0]  READ_LAT_RST     = 8'd20;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_GWRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MAC    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_ACCEPT = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_TICK   = 2'd2;

   // action codes
   localparam logic ACTION_ENQUEUE = 1'b0;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAN_W-1:0] chan;
      logic [ROW_W-1:0]  row;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_NOW,
      ST_CHAN,
      ST_SCAN0,
      ST_SCAN,
      ST_DECIDE,
      ST_ISSUE,
      ST_DIV,
      ST_SHIFT0,
      ST_SHIFT,
      ST_OUT
   } state_type;

endpackage

[rtl/core/pimrs_req_if.sv]
interface pimrs_req_if;
   import pimrs_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic [KIND_W-1:0] req_kind;
   logic [CHAN_W-1:0] channel_sel;
   logic [ROW_W-1:0]  row_addr;
   logic [TAG_W-1:0]  req_tag;
   logic              gpu_rows_busy;
   logic              gpu_column_busy;
   logic              gpu_column_ready;

   modport source (
      output valid, action, req_kind, channel_sel, row_addr, req_tag,
             gpu_rows_busy, gpu_column_busy, gpu_column_ready,
      input  ready
   );
   modport sink (
      input  valid, action, req_kind, channel_sel, row_addr, req_tag,
             gpu_rows_busy, gpu_column_busy, gpu_column_ready,
      output ready
   );
endinterface

[rtl/core/pimrs_rsp_if.sv]
interface pimrs_rsp_if;
   import pimrs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic                    pim_issued;
   logic [TAG_W-1:0]        issued_tag;
   logic [TIME_W-1:0]       done_clock;
   logic                    row_slot_allowed;
   logic                    gpu_column_tried;
   logic                    gpu_issued;
   logic [NUM_CHANNELS-1:0] close_rows_mask;
   logic                    pending;

   modport source (
      output valid, status, pim_issued, issued_tag, done_clock, row_slot_allowed,
             gpu_column_tried, gpu_issued, close_rows_mask, pending,
      input  ready
   );
   modport sink (
      input  valid, status, pim_issued, issued_tag, done_clock, row_slot_allowed,
             gpu_column_tried, gpu_issued, close_rows_mask, pending,
      output ready
   );
endinterface

[rtl/core/pimrs_csr_if.sv]
interface pimrs_csr_if;
   import pimrs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[rtl/core/pimrs_ram.sv]
module pimrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/pimrs_div.sv]
module pimrs_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pimrs_pkg::PS_W-1:0]  dividend,
   input  logic [pimrs_pkg::PER_W-1:0] divisor,
   output logic                        done,
   output logic [pimrs_pkg::PS_W-1:0]  quotient
);
   import pimrs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PS_W-1:0]      dvd_ff, dvd_in;
   logic [PER_W-1:0]     rem_ff, rem_in;
   logic [PER_W-1:0]     dsr_ff, dsr_in;
   logic [PER_W:0]       trial;
   logic                 qbit;

   // one restoring step per cycle, quotient shifts in from the bottom
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, dvd_ff[PS_W-1]};
      qbit    = trial >= {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(PS_W - 1);
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? PER_W'(trial - {1'b0, dsr_ff}) : PER_W'(trial);
         dvd_in = {dvd_ff[PS_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

[rtl/core/pim_request_scheduler_core.sv]
// PIM request scheduler. An enqueue beat appends a request to an in-order
// queue of 256 entries (or rejects it when full or malformed) and presents its
// result in the cycle after acceptance. A tick beat advances the controller
// clock, forms the current time in picoseconds with one 24x12 multiplier used
// twice, sweeps the 16 pseudo-channel windows, then, if any window is open,
// walks the queue one entry per cycle through the simple dual-port queue RAM
// until a channel-head request is found ready, arbitrates the column slot
// against the GPU and, on a PIM issue, works out the completion clock (through
// the bit-serial divider for group write and MAC, from the read latency for a
// read) and closes the gap left in the queue one entry per cycle. No beat is
// accepted until the result of the previous one has been taken. Control
// registers are meant to be written only while no beat is in flight.
module pim_request_scheduler_core (
   input  logic clock,
   input  logic reset,
   pimrs_req_if.sink   req_chan,
   pimrs_rsp_if.source rsp_chan,
   pimrs_csr_if.sink   csr_chan
);
   import pimrs_pkg::*;

   // control registers
   logic [IVAL_W-1:0] mac_ival_ff, io_ival_ff;
   logic [PER_W-1:0]  period_ff;
   logic              dual_ff;
   logic [DLY_W-1:0]  act_dly_ff, pre_dly_ff, read_lat_ff;
   logic [PER_W-1:0]  per_eff;

   // sequencer and queue state
   state_type         state_ff, state_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QCNT_W-1:0] idx_ff, idx_in;
   logic [CHAN_W-1:0] ch_ff, ch_in;
   logic [TIME_W-1:0] cycle_ff, cycle_in;
   logic [TIME_W-1:0] last_done_ff, last_done_in;
   logic              prefer_ff, prefer_in;

   // per-channel state
   logic [PS_W-1:0]   nit_ff  [NUM_CHANNELS];
   logic [PS_W-1:0]   nit_in  [NUM_CHANNELS];
   logic [TIME_W-1:0] rrc_ff  [NUM_CHANNELS];
   logic [TIME_W-1:0] rrc_in  [NUM_CHANNELS];
   logic [ROW_W-1:0]  orow_ff [NUM_CHANNELS];
   logic [ROW_W-1:0]  orow_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] ovalid_ff, ovalid_in;

   // per-tick working registers
   logic [HALF_W+PER_W-1:0] prod_lo_ff, prod_lo_in, prod_hi_ff, prod_hi_in;
   logic [PS_W-1:0]         now_ff, now_in;
   logic                    rows_busy_ff, rows_busy_in;
   logic                    col_busy_ff, col_busy_in;
   logic                    col_ready_ff, col_ready_in;
   logic                    trans_ff, trans_in;
   logic                    any_ff, any_in;
   logic                    found_ff, found_in;
   logic [NUM_CHANNELS-1:0] seen_ff, seen_in;
   entry_type               ent_ff, ent_in;

   // result registers
   logic [1:0]              status_ff, status_in;
   logic                    pim_ff, pim_in;
   logic [TAG_W-1:0]        tag_ff, tag_in;
   logic [TIME_W-1:0]       done_ff, done_in;
   logic                    row_slot_ff, row_slot_in;
   logic                    tried_ff, tried_in;
   logic                    gpu_ff, gpu_in;
   logic [NUM_CHANNELS-1:0] close_ff, close_in;

   // queue RAM, divider, multiplier
   logic                    ram_we;
   logic [QADDR_W-1:0]      ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
   logic                    div_start, div_done;
   logic [PS_W-1:0]         div_dividend, div_quot;
   logic [HALF_W-1:0]       mul_a;
   logic [HALF_W+PER_W-1:0] mul_p;

   logic       req_fire, bad_kind;
   entry_type  cur;
   logic [CHAN_W-1:0] pc;
   logic       time_ok, row_hit, row_ok, row_block, pim_go, gpu_go;
   logic [PS_W-1:0]   ival, nit_a, nit_b;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign bad_kind = !(req_chan.req_kind == KIND_GWRITE || req_chan.req_kind == KIND_MAC ||
                       req_chan.req_kind == KIND_READ);
   assign per_eff  = (period_ff == '0) ? PER_W'(1) : period_ff;
   assign cur      = entry_type'(ram_rdata);
   assign pc       = cur.chan;

   // shared multiplier: low half of the clock count, then the high half
   assign mul_a = (state_ff == ST_MUL_LO) ? cycle_ff[HALF_W-1:0] : cycle_ff[TIME_W-1:HALF_W];
   assign mul_p = mul_a * per_eff;

   // issue interval and window update for the chosen request
   assign ival  = (ent_ff.kind == KIND_MAC) ? PS_W'(mac_ival_ff) : PS_W'(io_ival_ff);
   assign nit_a = nit_ff[ent_ff.chan] + ival;
   assign nit_b = now_ff + ival;
   assign div_dividend = now_ff + ival + PS_W'(per_eff) - PS_W'(1);

   // row check for the entry under the scan
   assign time_ok   = now_ff >= nit_ff[pc];
   assign row_hit   = ovalid_ff[pc] && (orow_ff[pc] == cur.row);
   assign row_ok    = row_hit && (cycle_ff >= rrc_ff[pc]);
   assign row_block = !dual_ff && rows_busy_ff;

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      ch_in        = ch_ff;
      cycle_in     = cycle_ff;
      last_done_in = last_done_ff;
      prefer_in    = prefer_ff;
      nit_in       = nit_ff;
      rrc_in       = rrc_ff;
      orow_in      = orow_ff;
      ovalid_in    = ovalid_ff;
      prod_lo_in   = prod_lo_ff;
      prod_hi_in   = prod_hi_ff;
      now_in       = now_ff;
      rows_busy_in = rows_busy_ff;
      col_busy_in  = col_busy_ff;
      col_ready_in = col_ready_ff;
      trans_in     = trans_ff;
      any_in       = any_ff;
      found_in     = found_ff;
      seen_in      = seen_ff;
      ent_in       = ent_ff;
      status_in    = status_ff;
      pim_in       = pim_ff;
      tag_in       = tag_ff;
      done_in      = done_ff;
      row_slot_in  = row_slot_ff;
      tried_in     = tried_ff;
      gpu_in       = gpu_ff;
      close_in     = close_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[QADDR_W-1:0];
      ram_wdata    = ENTRY_W'({req_chan.req_kind, req_chan.channel_sel,
                               req_chan.row_addr, req_chan.req_tag});
      ram_raddr    = idx_ff[QADDR_W-1:0] + QADDR_W'(1);
      div_start    = 1'b0;
      pim_go       = 1'b0;
      gpu_go       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pim_in      = 1'b0;
               tag_in      = '0;
               done_in     = '0;
               row_slot_in = 1'b0;
               tried_in    = 1'b0;
               gpu_in      = 1'b0;
               close_in    = '0;
               if (req_chan.action == ACTION_ENQUEUE) begin
                  if (bad_kind || count_ff == QCNT_W'(QUEUE_DEPTH)) begin
                     status_in = STATUS_REJECT;
                  end else begin
                     status_in = STATUS_ACCEPT;
                     ram_we    = 1'b1;
                     count_in  = count_ff + 1'b1;
                  end
                  state_in = ST_OUT;
               end else begin
                  status_in    = STATUS_TICK;
                  cycle_in     = cycle_ff + 1'b1;
                  rows_busy_in = req_chan.gpu_rows_busy;
                  col_busy_in  = req_chan.gpu_column_busy;
                  col_ready_in = req_chan.gpu_column_ready;
                  trans_in     = 1'b0;
                  any_in       = 1'b0;
                  found_in     = 1'b0;
                  ch_in        = '0;
                  state_in     = ST_MUL_LO;
               end
            end
         end
         ST_MUL_LO: begin
            prod_lo_in = mul_p;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            prod_hi_in = mul_p;
            state_in   = ST_NOW;
         end
         ST_NOW: begin
            now_in   = PS_W'({prod_hi_ff, HALF_W'(0)}) + PS_W'(prod_lo_ff);
            state_in = ST_CHAN;
         end
         // channel sweep: row transition and any open issue window
         ST_CHAN: begin
            if (!dual_ff && rrc_ff[ch_ff] > cycle_ff) begin
               trans_in = 1'b1;
            end
            if (now_ff >= nit_ff[ch_ff]) begin
               any_in = 1'b1;
            end
            if (ch_ff == CHAN_W'(NUM_CHANNELS - 1)) begin
               state_in = any_in ? ST_SCAN0 : ST_DECIDE;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         ST_SCAN0: begin
            ram_raddr = '0;
            idx_in    = '0;
            seen_in   = '0;
            state_in  = ST_SCAN;
         end
         // in-order walk, only the first request of each channel counts
         ST_SCAN: begin
            if (idx_ff == count_ff) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (!seen_ff[pc]) begin
                  seen_in[pc] = 1'b1;
                  if (time_ok) begin
                     if (row_hit) begin
                        if (row_ok) begin
                           found_in = 1'b1;
                           ent_in   = cur;
                           idx_in   = idx_ff;
                           state_in = ST_DECIDE;
                        end
                     end else if (!row_block) begin
                        if (!dual_ff) begin
                           close_in[pc] = 1'b1;
                        end
                        ovalid_in[pc] = 1'b1;
                        orow_in[pc]   = cur.row;
                        rrc_in[pc]    = cycle_ff + TIME_W'(act_dly_ff) +
                                        (ovalid_ff[pc] ? TIME_W'(pre_dly_ff) : '0);
                     end
                  end
               end
            end
         end
         // column slot arbitration against the GPU
         ST_DECIDE: begin
            row_slot_in = !trans_ff;
            if (found_ff && (!(rows_busy_ff || col_busy_ff) || prefer_ff || trans_ff)) begin
               pim_go = 1'b1;
            end else if (!trans_ff) begin
               tried_in = 1'b1;
               gpu_go   = col_ready_ff;
               if (!col_ready_ff && found_ff) begin
                  pim_go = 1'b1;
               end
            end
            pim_in = pim_go;
            gpu_in = gpu_go;
            if (pim_go) begin
               prefer_in = 1'b0;
               state_in  = ST_ISSUE;
            end else begin
               if (gpu_go) begin
                  prefer_in = 1'b1;
               end
               state_in = ST_OUT;
            end
         end
         ST_ISSUE: begin
            nit_in[ent_ff.chan] = (nit_a > nit_b) ? nit_a : nit_b;
            tag_in = ent_ff.tag;
            if (ent_ff.kind == KIND_READ) begin
               done_in  = cycle_ff + TIME_W'(read_lat_ff);
               state_in = ST_SHIFT0;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               done_in  = div_quot[TIME_W-1:0];
               state_in = ST_SHIFT0;
            end
         end
         // close the gap left by the issued entry
         ST_SHIFT0: begin
            if (done_ff > last_done_ff) begin
               last_done_in = done_ff;
            end
            if (idx_ff + 1'b1 == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_OUT;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[QADDR_W-1:0];
            ram_wdata = ram_rdata;
            ram_raddr = idx_ff[QADDR_W-1:0] + QADDR_W'(2);
            if (idx_ff + QCNT_W'(2) == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cycle_ff     <= '0;
         last_done_ff <= '0;
         prefer_ff    <= 1'b0;
         ovalid_ff    <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            nit_ff[c] <= '0;
            rrc_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cycle_ff     <= cycle_in;
         last_done_ff <= last_done_in;
         prefer_ff    <= prefer_in;
         ovalid_ff    <= ovalid_in;
         nit_ff       <= nit_in;
         rrc_ff       <= rrc_in;
      end
   end

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ival_ff <= MAC_INTERVAL_RST;
         io_ival_ff  <= IO_INTERVAL_RST;
         period_ff   <= CLOCK_PERIOD_RST;
         dual_ff     <= 1'b1;
         act_dly_ff  <= ACT_DELAY_RST;
         pre_dly_ff  <= PRE_DELAY_RST;
         read_lat_ff <= READ_LAT_RST;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.reg_index)
            CSR_MAC_INTERVAL: mac_ival_ff <= csr_chan.wdata;
            CSR_IO_INTERVAL:  io_ival_ff  <= csr_chan.wdata;
            CSR_CLOCK_PERIOD: period_ff   <= csr_chan.wdata[PER_W-1:0];
            CSR_DUAL_ROW:     dual_ff     <= csr_chan.wdata[0];
            CSR_ACT_DELAY:    act_dly_ff  <= csr_chan.wdata[DLY_W-1:0];
            CSR_PRE_DELAY:    pre_dly_ff  <= csr_chan.wdata[DLY_W-1:0];
            CSR_READ_LAT:     read_lat_ff <= csr_chan.wdata[DLY_W-1:0];
            default: ;
         endcase
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      ch_ff        <= ch_in;
      orow_ff      <= orow_in;
      prod_lo_ff   <= prod_lo_in;
      prod_hi_ff   <= prod_hi_in;
      now_ff       <= now_in;
      rows_busy_ff <= rows_busy_in;
      col_busy_ff  <= col_busy_in;
      col_ready_ff <= col_ready_in;
      trans_ff     <= trans_in;
      any_ff       <= any_in;
      found_ff     <= found_in;
      seen_ff      <= seen_in;
      ent_ff       <= ent_in;
      status_ff    <= status_in;
      pim_ff       <= pim_in;
      tag_ff       <= tag_in;
      done_ff      <= done_in;
      row_slot_ff  <= row_slot_in;
      tried_ff     <= tried_in;
      gpu_ff       <= gpu_in;
      close_ff     <= close_in;
   end

   pimrs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pimrs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (per_eff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ports
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid            = (state_ff == ST_OUT);
   assign rsp_chan.status           = status_ff;
   assign rsp_chan.pim_issued       = pim_ff;
   assign rsp_chan.issued_tag       = tag_ff;
   assign rsp_chan.done_clock       = done_ff;
   assign rsp_chan.row_slot_allowed = row_slot_ff;
   assign rsp_chan.gpu_column_tried = tried_ff;
   assign rsp_chan.gpu_issued       = gpu_ff;
   assign rsp_chan.close_rows_mask  = close_ff;
   assign rsp_chan.pending          = (count_ff != '0) || (cycle_ff < last_done_ff);

   // accepted enqueue grows the queue by one
   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.action == ACTION_ENQUEUE && !bad_kind &&
       count_ff < QCNT_W'(QUEUE_DEPTH)) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on accepted enqueue");

   // GPU and PIM never share the column slot
   a_gpu_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.gpu_issued) |-> (rsp_chan.gpu_column_tried &&
                                                   !rsp_chan.pim_issued))
      else $error("GPU column issue without offer or alongside PIM issue");

   // latest completion covers the one just reported
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.pim_issued) |-> last_done_ff >= rsp_chan.done_clock)
      else $error("last completion behind reported completion");

   // divider answers only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside of its wait state");

endmodule
